FILE: hdl/lcrf_pkg.sv
// shared types and constants of the line counting receive fifo
package lcrf_pkg;

    localparam int RING_DEPTH = 256;
    localparam int IDX_W      = $clog2(RING_DEPTH);

    localparam logic       OP_PUSH = 1'b0;
    localparam logic       OP_POP  = 1'b1;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic [7:0] LINE_END_RESET = 8'd13;
    localparam logic [7:0] LINE_COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [1:0] status;
        logic       byte_available;
        logic       line_available;
        logic [7:0] lines_held;
    } out_item_t;

endpackage

FILE: hdl/lcrf_ram.sv
// generic single write port ram with registered read
module lcrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/lcrf_ctrl.sv
// pointer, line count and sequencing logic around the ring memory
module lcrf_ctrl
    import lcrf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    input  logic [7:0] line_end_code,
    output logic       res_valid,
    input  logic       res_ready,
    output out_item_t  res_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);
    localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [7:0]       line_cnt_reg, line_cnt_next;
    logic [7:0]       read_byte_reg, read_byte_next;
    logic [1:0]       status_reg, status_next;

    logic [IDX_W-1:0] wr_idx_inc, rd_idx_inc;
    logic             ring_full, ring_empty;
    logic             ram_we, ram_re;
    logic [7:0]       ram_rdata;

    assign wr_idx_inc = (wr_idx_reg == IDX_LAST) ? '0 : wr_idx_reg + IDX_ONE;
    assign rd_idx_inc = (rd_idx_reg == IDX_LAST) ? '0 : rd_idx_reg + IDX_ONE;
    assign ring_full  = (wr_idx_inc == rd_idx_reg);
    assign ring_empty = (wr_idx_reg == rd_idx_reg);

    assign s_ready = (state_reg == ST_IDLE);

    lcrf_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wr_idx_reg),
        .wr_data (s_data.data_byte),
        .rd_en   (ram_re),
        .rd_addr (rd_idx_reg),
        .rd_data (ram_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        line_cnt_next  = line_cnt_reg;
        read_byte_next = read_byte_reg;
        status_next    = status_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    read_byte_next = '0;
                    status_next    = STATUS_DONE;
                    state_next     = ST_HOLD;
                    if (s_data.operation == OP_PUSH) begin
                        if (ring_full) begin
                            status_next = STATUS_FULL;
                        end else begin
                            ram_we      = 1'b1;
                            wr_idx_next = wr_idx_inc;
                            if (s_data.data_byte == line_end_code &&
                                line_cnt_reg != LINE_COUNT_MAX) begin
                                line_cnt_next = line_cnt_reg + 8'd1;
                            end
                        end
                    end else begin
                        if (ring_empty) begin
                            status_next = STATUS_EMPTY;
                        end else begin
                            ram_re      = 1'b1;
                            rd_idx_next = rd_idx_inc;
                            state_next  = ST_READ;
                        end
                    end
                end
            end
            ST_READ: begin
                read_byte_next = ram_rdata;
                state_next     = ST_HOLD;
                if (ram_rdata == line_end_code && line_cnt_reg != 8'd0) begin
                    line_cnt_next = line_cnt_reg - 8'd1;
                end
            end
            ST_HOLD: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wr_idx_reg   <= '0;
            rd_idx_reg   <= '0;
            line_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            wr_idx_reg   <= wr_idx_next;
            rd_idx_reg   <= rd_idx_next;
            line_cnt_reg <= line_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        read_byte_reg <= read_byte_next;
        status_reg    <= status_next;
    end

    assign res_valid               = (state_reg == ST_HOLD);
    assign res_data.read_byte      = read_byte_reg;
    assign res_data.status         = status_reg;
    assign res_data.byte_available = !ring_empty;
    assign res_data.line_available = (line_cnt_reg != 8'd0);
    assign res_data.lines_held     = line_cnt_reg;

endmodule

FILE: hdl/line_counting_receive_fifo_unit.sv
// top level of the line counting receive fifo
//
// usage
// - s_ channel: one transaction is a push of a received byte (operation 0)
//   or a pop of the oldest byte (operation 1)
// - m_ channel: exactly one result transaction per input transaction, in
//   order, with the popped byte, a status code, byte/line availability and
//   the number of line-end bytes held
// - cfg_ channel: writes the line-end code; always ready, write only while
//   no transaction is in flight
// sequencing: a push goes from idle to the hold state, a pop from idle
//   through a read state, which waits for the registered ring memory read,
//   to the hold state; the result then passes into the output register, and
//   no new transaction is taken until the control unit is back in idle
// reset: pointers and line count clear, line-end code returns to 13; the
//   ring memory itself is not cleared and needs no clearing pass
// receiver stall: the result sits in the output register while the next
//   transaction is taken and processed; that one then waits in the control
//   unit and the input stalls until the output register frees up
module line_counting_receive_fifo_unit
    import lcrf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic [7:0] line_end_reg;

    logic       res_valid;
    logic       res_ready;
    out_item_t  res_data;

    logic       m_valid_reg;
    out_item_t  m_data_reg;

    // configuration register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_end_reg <= LINE_END_RESET;
        end else if (cfg_valid) begin
            line_end_reg <= cfg_data;
        end
    end

    lcrf_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .line_end_code (line_end_reg),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_data      (res_data)
    );

    // output register decouples the receiver from the control unit
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: test/line_counting_receive_fifo_unit_test.sv
// self-checking testbench of the line counting receive fifo unit
module line_counting_receive_fifo_unit_test;
    import lcrf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_TIME  = 6;
    localparam int PHASE_COUNT  = 8;

    // clock, reset and the ports of the block
    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_item_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_item_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = 8'd0;

    // byte requests waiting for the driver, and replies the ring model predicts
    in_item_t   byte_requests[$];
    out_item_t  ring_replies_due[$];

    // handshake flags seen at the last rising edge
    logic       in_accepted  = 1'b0;
    logic       cfg_accepted = 1'b0;

    // progress counters
    int         queued_count   = 0;
    int         accepted_count = 0;
    int         replies_seen   = 0;
    int         mismatch_count = 0;
    int         cycle_count    = 0;

    // idling control and long receiver hold-off requests
    bit         idling_on  = 1'b1;
    int         holds_asked = 0;

    // ring model state
    logic [7:0] model_ring[RING_DEPTH];
    logic [7:0] model_wr_ptr   = '0;
    logic [7:0] model_rd_ptr   = '0;
    logic [7:0] model_lines    = '0;
    logic [7:0] model_line_end = LINE_END_RESET;

    // what the run went through
    int         dropped_pushes  = 0;
    int         empty_pops      = 0;
    int         line_end_pushes = 0;
    int         saturated_ends  = 0;
    int         floored_pops    = 0;

    line_counting_receive_fifo_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // advance the ring model by one request and return the reply it gives
    function automatic out_item_t step_ring_model(input in_item_t req);
        out_item_t reply;
        logic [7:0] popped;
        reply  = '0;
        popped = 8'd0;
        reply.status = STATUS_DONE;
        if (req.operation == OP_PUSH) begin
            // one slot stays free, so the ring is full one short of its depth
            if (8'(model_wr_ptr + 8'd1) == model_rd_ptr) begin
                reply.status = STATUS_FULL;
                dropped_pushes++;
            end else begin
                model_ring[model_wr_ptr] = req.data_byte;
                model_wr_ptr = model_wr_ptr + 8'd1;
                if (req.data_byte == model_line_end) begin
                    line_end_pushes++;
                    // count saturates at its top
                    if (model_lines == LINE_COUNT_MAX)
                        saturated_ends++;
                    else
                        model_lines = model_lines + 8'd1;
                end
            end
        end else begin
            if (model_wr_ptr == model_rd_ptr) begin
                reply.status = STATUS_EMPTY;
                empty_pops++;
            end else begin
                popped = model_ring[model_rd_ptr];
                model_rd_ptr = model_rd_ptr + 8'd1;
                if (popped == model_line_end) begin
                    // a line-end byte stored under an older code leaves the count at zero
                    if (model_lines == 8'd0)
                        floored_pops++;
                    else
                        model_lines = model_lines - 8'd1;
                end
            end
        end
        reply.read_byte      = popped;
        reply.byte_available = (model_wr_ptr != model_rd_ptr);
        reply.line_available = (model_lines != 8'd0);
        reply.lines_held     = model_lines;
        return reply;
    endfunction

    // rising edge: note handshakes, predict accepted requests, check replies
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            in_accepted  <= 1'b0;
            cfg_accepted <= 1'b0;
        end else begin
            in_accepted  <= s_valid && s_ready;
            cfg_accepted <= cfg_valid && cfg_ready;
            if (cfg_valid && cfg_ready)
                model_line_end = cfg_data;
            if (s_valid && s_ready) begin
                ring_replies_due.push_back(step_ring_model(s_data));
                accepted_count <= accepted_count + 1;
            end
            if (m_valid && m_ready) begin
                replies_seen <= replies_seen + 1;
                if (ring_replies_due.size() == 0) begin
                    $error("reply transaction with none outstanding: %p", m_data);
                    mismatch_count++;
                end else begin
                    want = ring_replies_due.pop_front();
                    if (m_data.read_byte !== want.read_byte) begin
                        $error("read_byte expected %0d actual %0d",
                               want.read_byte, m_data.read_byte);
                        mismatch_count++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, m_data.status);
                        mismatch_count++;
                    end
                    if (m_data.byte_available !== want.byte_available) begin
                        $error("byte_available expected %0d actual %0d",
                               want.byte_available, m_data.byte_available);
                        mismatch_count++;
                    end
                    if (m_data.line_available !== want.line_available) begin
                        $error("line_available expected %0d actual %0d",
                               want.line_available, m_data.line_available);
                        mismatch_count++;
                    end
                    if (m_data.lines_held !== want.lines_held) begin
                        $error("lines_held expected %0d actual %0d",
                               want.lines_held, m_data.lines_held);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // request driver: a new transaction is offered only once the last one is taken
    always @(negedge aclk) begin
        int send_gap;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else if (!s_valid || in_accepted) begin
            if (send_gap == 0 && idling_on && $urandom_range(0, 11) == 0)
                send_gap = $urandom_range(1, 13);
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (byte_requests.size() != 0) begin
                s_data  <= byte_requests.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // reply receiver: random stall bursts, plus long hold-offs on request
    always @(negedge aclk) begin
        int stall_left;
        int hold_left;
        int holds_served;
        if (!aresetn) begin
            m_ready      <= 1'b0;
            stall_left   = 0;
            hold_left    = 0;
            holds_served = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 12);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic queue_request(input logic op, input logic [7:0] value);
        in_item_t req;
        req.operation = op;
        req.data_byte = value;
        byte_requests.push_back(req);
        queued_count++;
    endtask

    // wait until every queued transaction is taken and answered, then let the block settle
    task automatic wait_ring_idle();
        do @(negedge aclk);
        while (accepted_count != queued_count || ring_replies_due.size() != 0);
        repeat (SETTLE_TIME) @(negedge aclk);
    endtask

    task automatic write_line_end(input logic [7:0] code);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= code;
        do @(negedge aclk);
        while (!cfg_accepted);
        cfg_valid <= 1'b0;
    endtask

    // random phase: push share and line-end share in percent, content random otherwise
    task automatic queue_random_phase(input int count, input int push_pct, input int end_pct);
        logic [7:0] value;
        repeat (count) begin
            if ($urandom_range(0, 99) < push_pct) begin
                if ($urandom_range(0, 99) < end_pct)
                    value = model_line_end;
                else if ($urandom_range(0, 15) == 0)
                    value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                else
                    value = 8'($urandom_range(0, 255));
                queue_request(OP_PUSH, value);
            end else begin
                queue_request(OP_POP, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        // phase plan: a code of -1 picks a random line-end code
        int phase_code[PHASE_COUNT] = '{13, 0, 0, 255, 255, 128, -1, -1};
        int phase_len[PHASE_COUNT]  = '{250, 120, 280, 270, 40, 300, 300, 280};
        int phase_push[PHASE_COUNT] = '{55, 0, 100, 0, 100, 45, 55, 50};
        int phase_end[PHASE_COUNT]  = '{20, 0, 100, 0, 100, 30, 25, 15};
        bit phase_hold[PHASE_COUNT] = '{1, 0, 1, 0, 0, 0, 1, 0};

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // directed: empty pop, byte extremes, line ends under the reset code
        queue_request(OP_POP,  8'hFF);
        queue_request(OP_PUSH, 8'h00);
        queue_request(OP_PUSH, 8'hFF);
        queue_request(OP_PUSH, LINE_END_RESET);
        queue_request(OP_PUSH, LINE_END_RESET);
        queue_request(OP_POP,  8'h00);
        queue_request(OP_POP,  8'hAA);
        queue_request(OP_POP,  8'h55);
        queue_request(OP_PUSH, 8'h0A);
        queue_request(OP_PUSH, 8'h0A);
        wait_ring_idle();

        // code changes while bytes are held: the second 0x0A pop finds the count at zero
        write_line_end(8'h0A);
        queue_request(OP_POP,  8'h00);
        queue_request(OP_POP,  8'h00);
        queue_request(OP_POP,  8'h00);
        queue_request(OP_POP,  8'h00);
        queue_request(OP_PUSH, 8'h0A);
        wait_ring_idle();

        // register extremes
        write_line_end(8'h00);
        queue_request(OP_PUSH, 8'h00);
        wait_ring_idle();
        write_line_end(8'hFF);
        queue_request(OP_PUSH, 8'hFF);
        queue_request(OP_POP,  8'h00);
        queue_request(OP_POP,  8'h00);
        queue_request(OP_POP,  8'h00);
        queue_request(OP_POP,  8'h00);
        wait_ring_idle();

        // random phases: mixed traffic, then emptying, filling to full with line ends,
        // emptying under a new code so the count stays at its top, saturated pushes, then mixed traffic again
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_line_end(phase_code[p] < 0 ? 8'($urandom_range(0, 255)) : 8'(phase_code[p]));
            // no idling at all in the closing phase
            idling_on = (p != PHASE_COUNT - 1);
            if (phase_hold[p])
                holds_asked++;
            queue_random_phase(phase_len[p], phase_push[p], phase_end[p]);
            wait_ring_idle();
        end

        $display("ran %0d transactions, %0d replies; %0d line-end pushes,",
                 accepted_count, replies_seen, line_end_pushes);
        $display("%0d dropped pushes, %0d empty pops", dropped_pushes, empty_pops);
        $display("line count held at its top %0d times, at zero on a line-end pop %0d times",
                 saturated_ends, floored_pops);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
